[design/csg_pkg.sv]
// shared types and constants of the cross sharpen and gamma block
package csg_pkg;

	localparam int COL_W        = 11;
	localparam int ROW_W        = 12;
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int REG_IDX_W    = 1;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 48;
	localparam int QUEUE_AW     = 2;
	localparam int EMIT_N       = 4;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// pending results of one pixel, lowest bit released first
	localparam int EMIT_UP_LEFT   = 0;
	localparam int EMIT_UP_END    = 1;
	localparam int EMIT_LAST_LEFT = 2;
	localparam int EMIT_LAST_END  = 3;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		pix_t             upper;
		pix_t             mid;
		pix_t             low;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             col_nz;
		logic             row_nz;
		logic             row_end;
		logic             last_row;
	} job_t;

endpackage

[design/csg_front.sv]
// front end: pixel intake, raster counters, rotating line memories, job build
module csg_front
	import csg_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  job_valid,
	input  logic                  job_ready,
	output job_t                  job
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
	localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_W - 1);
	localparam logic [RW-1:0] RST_LAST_ROW = RW'(RST_H - 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;
	logic [2:0]    cur_oh_q;

	logic             vld_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             col_nz_s1;
	logic             row_nz_s1;
	logic             row_ge2_s1;
	logic             row_end_s1;
	logic             last_row_s1;
	logic [2:0]       mid_oh_s1;
	logic [2:0]       old_oh_s1;
	pix_t             rd_s1 [3];

	logic [WIDTH_REG_W-1:0]  wv;
	logic [HEIGHT_REG_W-1:0] hv;
	logic acc;
	logic row_end;
	logic last_row;
	pix_t mid_pix;
	pix_t old_pix;

	assign wv       = wr_data[WIDTH_REG_W-1:0];
	assign hv       = wr_data[HEIGHT_REG_W-1:0];
	assign s_tready = !vld_s1 || job_ready;
	assign acc      = s_tvalid && s_tready;
	assign row_end  = col_q >= last_col_q;
	assign last_row = row_q >= last_row_q;

	// configuration, stored as clamped last column and last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= RST_LAST_COL;
			last_row_q <= RST_LAST_ROW;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH: begin
					if (wv == '0)
						last_col_q <= '0;
					else if (32'(wv) > 32'(MAX_WIDTH))
						last_col_q <= CW'(MAX_WIDTH - 1);
					else
						last_col_q <= CW'(wv - WIDTH_REG_W'(1));
				end
				REG_IMAGE_HEIGHT: begin
					if (hv == '0)
						last_row_q <= '0;
					else if (32'(hv) > 32'(MAX_HEIGHT))
						last_row_q <= RW'(MAX_HEIGHT - 1);
					else
						last_row_q <= RW'(hv - HEIGHT_REG_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

	// raster counters and line memory roles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			cur_oh_q <= 3'b001;
		end else if (acc) begin
			if (row_end) begin
				col_q    <= '0;
				row_q    <= last_row ? '0 : row_q + RW'(1);
				cur_oh_q <= {cur_oh_q[1:0], cur_oh_q[2]};
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_line
		pix_t mem [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (acc) begin
				rd_s1[g] <= mem[col_q];
				if (cur_oh_q[g])
					mem[col_q] <= pix_t'(s_tdata);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1      <= pix_t'(s_tdata);
			col_s1      <= COL_W'(col_q);
			row_s1      <= ROW_W'(row_q);
			col_nz_s1   <= col_q != '0;
			row_nz_s1   <= row_q != '0;
			row_ge2_s1  <= row_q > RW'(1);
			row_end_s1  <= row_end;
			last_row_s1 <= last_row;
			mid_oh_s1   <= {cur_oh_q[0], cur_oh_q[2:1]};
			old_oh_s1   <= {cur_oh_q[1:0], cur_oh_q[2]};
		end
	end

	always_comb begin
		mid_pix = '0;
		old_pix = '0;
		for (int g = 0; g < 3; g++) begin
			if (mid_oh_s1[g])
				mid_pix = mid_pix | rd_s1[g];
			if (old_oh_s1[g])
				old_pix = old_pix | rd_s1[g];
		end
	end

	always_comb begin
		job.upper    = row_ge2_s1 ? old_pix : mid_pix;
		job.mid      = mid_pix;
		job.low      = pix_s1;
		job.col      = col_s1;
		job.row      = row_s1;
		job.col_nz   = col_nz_s1;
		job.row_nz   = row_nz_s1;
		job.row_end  = row_end_s1;
		job.last_row = last_row_s1;
	end

	assign job_valid = vld_s1;

`ifndef NO_ASSERTIONS
	a_roles_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cur_oh_q))
		else $error("line memory roles not one-hot");

	a_rotate_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && row_end) |=> $stable(cur_oh_q))
		else $error("line memory roles moved mid-row");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !job_ready) |=> (vld_s1 && $stable(job)))
		else $error("stalled job changed");
`endif

endmodule

[design/csg_queue.sv]
// short job queue between front and back ends
module csg_queue
	import csg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int DEPTH = 2 ** QUEUE_AW;

	job_t              slot_q [DEPTH];
	logic [QUEUE_AW:0] wr_ptr_q;
	logic [QUEUE_AW:0] rd_ptr_q;

	assign empty    = wr_ptr_q == rd_ptr_q;
	assign full     = (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]) &&
	                  (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]);
	assign pop_data = slot_q[rd_ptr_q[QUEUE_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + (QUEUE_AW + 1)'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + (QUEUE_AW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q[QUEUE_AW-1:0]] <= push_data;
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

[design/csg_back.sv]
// back end: column window, result sequencing, sharpen, gamma curve, output register
module csg_back
	import csg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  job_t                  q_job,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	function automatic logic [2047:0] build_gamma();
		logic [2047:0]   rom;
		longint unsigned p;
		longint unsigned t;
		longint unsigned q;
		logic [7:0]      n;
		logic [7:0]      cand;
		rom = '0;
		for (int i = 0; i < 256; i++) begin
			p = 64'(i);
			p = p * p * p * p * p * p;
			n = '0;
			for (int b = 7; b >= 0; b--) begin
				cand = n | 8'(1 << b);
				t    = 64'(cand);
				q    = t * t * t * t * t * 64'(255);
				if (q <= p)
					n = cand;
			end
			rom[i*8 +: 8] = n;
		end
		return rom;
	endfunction

	localparam logic [2047:0] GAMMA_ROM = build_gamma();

	function automatic logic [7:0] sharpen_ch(input logic [7:0] c, input logic [7:0] l,
		input logic [7:0] r, input logic [7:0] u, input logic [7:0] d);
		logic [9:0] sum;
		logic [9:0] twice;
		logic [9:0] quarter;
		logic [9:0] diff;
		logic [7:0] res;
		sum     = 10'(l) + 10'(r) + 10'(u) + 10'(d);
		twice   = {1'b0, c, 1'b0};
		quarter = {2'b00, sum[9:2]};
		diff    = twice - quarter;
		if (twice < quarter)
			res = '0;
		else if (diff > 10'd255)
			res = 8'd255;
		else
			res = diff[7:0];
		return res;
	endfunction

	function automatic pix_t sharpen_pix(input pix_t c, input pix_t l, input pix_t r,
		input pix_t u, input pix_t d);
		pix_t o;
		o.red   = sharpen_ch(c.red, l.red, r.red, u.red, d.red);
		o.green = sharpen_ch(c.green, l.green, r.green, u.green, d.green);
		o.blue  = sharpen_ch(c.blue, l.blue, r.blue, u.blue, d.blue);
		return o;
	endfunction

	function automatic logic [7:0] gamma_ch(input logic [7:0] v);
		return GAMMA_ROM[{v, 3'b000} +: 8];
	endfunction

	function automatic logic [EMIT_N-1:0] emit_mask(input job_t j);
		logic [EMIT_N-1:0] m;
		m                 = '0;
		m[EMIT_UP_LEFT]   = j.row_nz && j.col_nz;
		m[EMIT_UP_END]    = j.row_nz && j.row_end;
		m[EMIT_LAST_LEFT] = j.last_row && j.col_nz;
		m[EMIT_LAST_END]  = j.last_row && j.row_end;
		return m;
	endfunction

	logic [EMIT_N-1:0] mask_q;
	job_t              cur_q;
	job_t              p1_q;
	job_t              p2_q;

	logic             vld_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             last_s1;

	logic             vld_s2;
	pix_t             pix_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic             last_s2;

	logic              s2_ready;
	logic              s1_ready;
	logic              issue;
	logic [EMIT_N-1:0] pick;
	logic [EMIT_N-1:0] rem;
	logic              is_last;
	logic              is_end;
	pix_t              ctr_cur, ctr_p1, ctr_p2;
	pix_t              up_cur, up_p1, dn_cur, dn_p1;
	pix_t              op_c, op_l, op_r, op_u, op_d;
	logic [COL_W-1:0]  op_col;
	logic [ROW_W-1:0]  op_row;

	assign s2_ready = !vld_s2 || m_tready;
	assign s1_ready = !vld_s1 || s2_ready;
	assign issue    = (mask_q != '0) && s1_ready;
	assign pick     = mask_q & (~mask_q + EMIT_N'(1));
	assign rem      = issue ? (mask_q & ~pick) : mask_q;
	assign q_pop    = !q_empty && (rem == '0);
	assign is_last  = pick[EMIT_LAST_LEFT] || pick[EMIT_LAST_END];
	assign is_end   = pick[EMIT_UP_END] || pick[EMIT_LAST_END];

	// row above the current one uses mid as centre, the last row uses low
	always_comb begin
		ctr_cur = is_last ? cur_q.low : cur_q.mid;
		ctr_p1  = is_last ? p1_q.low : p1_q.mid;
		ctr_p2  = is_last ? p2_q.low : p2_q.mid;
		up_cur  = is_last ? (cur_q.row_nz ? cur_q.mid : cur_q.low) : cur_q.upper;
		up_p1   = is_last ? (p1_q.row_nz ? p1_q.mid : p1_q.low) : p1_q.upper;
		dn_cur  = cur_q.low;
		dn_p1   = p1_q.low;
		if (is_end) begin
			op_c   = ctr_cur;
			op_r   = ctr_cur;
			op_l   = cur_q.col_nz ? ctr_p1 : ctr_cur;
			op_u   = up_cur;
			op_d   = dn_cur;
			op_col = cur_q.col;
		end else begin
			op_c   = ctr_p1;
			op_r   = ctr_cur;
			op_l   = p1_q.col_nz ? ctr_p2 : ctr_p1;
			op_u   = up_p1;
			op_d   = dn_p1;
			op_col = cur_q.col - COL_W'(1);
		end
		op_row = is_last ? cur_q.row : cur_q.row - ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= '0;
		else if (q_pop)
			mask_q <= emit_mask(q_job);
		else
			mask_q <= rem;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
			p1_q  <= cur_q;
			p2_q  <= p1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_ready)
				vld_s1 <= issue;
			if (s2_ready)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pix_s1  <= sharpen_pix(op_c, op_l, op_r, op_u, op_d);
			col_s1  <= op_col;
			row_s1  <= op_row;
			last_s1 <= is_last && is_end;
		end
		if (s2_ready && vld_s1) begin
			pix_s2.red   <= gamma_ch(pix_s1.red);
			pix_s2.green <= gamma_ch(pix_s1.green);
			pix_s2.blue  <= gamma_ch(pix_s1.blue);
			col_s2       <= col_s1;
			row_s2       <= row_s1;
			last_s2      <= last_s1;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {1'b0, row_s2, col_s2, pix_s2};
	assign m_tlast  = last_s2;

`ifndef NO_ASSERTIONS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s2_ready) |=> (vld_s1 && $stable(pix_s1) && $stable(col_s1)))
		else $error("stalled result changed");
`endif

endmodule

[design/cross_sharpen_gamma_lut.sv]
// top level of the cross sharpen and gamma curve pixel block
// Takes one RGB pixel per clock in raster order while s_tready is high and returns
// each pixel sharpened with the cross-shaped kernel (edge pixels repeated at the
// borders) and mapped through a gamma 1.2 curve, one row and one column behind the
// input; every result carries its column, row and a frame end flag on tlast. The
// front end takes a pixel every clock while the job queue has room: three rotating
// line memories of MAX_WIDTH pixels are read at one address per pixel. The back end
// releases one result per clock while m_tready is high. A pixel gives no result on
// the first row of a frame taller than one row, one mid-row and two at a row end; on
// the last row it gives two, and four at the row end. A four-entry job queue absorbs
// the row end bursts and holds input back when it fills, so new pixels are taken
// while earlier jobs still wait. The line memories need no clearing after reset.
// The user must write width and height only between frames or while the block is
// idle; the block itself does not enforce this.
module cross_sharpen_gamma_lut
	import csg_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // red_out, green_out, blue_out, out_column, out_row
	output logic                  m_tlast    // frame_last
);

	job_t front_job;
	job_t queue_job;
	logic front_valid;
	logic queue_full;
	logic queue_empty;
	logic queue_pop;

	csg_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.job_valid (front_valid),
		.job_ready (!queue_full),
		.job       (front_job)
	);

	csg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid && !queue_full),
		.push_data (front_job),
		.full      (queue_full),
		.pop       (queue_pop),
		.pop_data  (queue_job),
		.empty     (queue_empty)
	);

	csg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_job    (queue_job),
		.q_empty  (queue_empty),
		.q_pop    (queue_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
